// ===== hw/rtl/qcse_pkg.sv =====
// Shared types and constants of the quad contour segment extractor.
package qcse_pkg;

   localparam int VALUE_W   = 32;
   localparam int LEVEL_W   = 6;
   localparam int COUNT_W   = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_Z_AXIS_LOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_AXIS_HIGH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT  = 2'd2;

   localparam logic [VALUE_W-1:0] Z_AXIS_LOW_RESET  = 32'd0;
   localparam logic [VALUE_W-1:0] Z_AXIS_HIGH_RESET = 32'd65536;
   localparam logic [COUNT_W-1:0] LEVEL_COUNT_RESET = 7'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] corner0_x;
      logic signed [VALUE_W-1:0] corner0_y;
      logic signed [VALUE_W-1:0] corner0_z;
      logic signed [VALUE_W-1:0] corner1_x;
      logic signed [VALUE_W-1:0] corner1_y;
      logic signed [VALUE_W-1:0] corner1_z;
      logic signed [VALUE_W-1:0] corner2_x;
      logic signed [VALUE_W-1:0] corner2_y;
      logic signed [VALUE_W-1:0] corner2_z;
      logic signed [VALUE_W-1:0] corner3_x;
      logic signed [VALUE_W-1:0] corner3_y;
      logic signed [VALUE_W-1:0] corner3_z;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]        level_index;
      logic signed [VALUE_W-1:0] start_x;
      logic signed [VALUE_W-1:0] start_y;
      logic signed [VALUE_W-1:0] end_x;
      logic signed [VALUE_W-1:0] end_y;
      logic                      no_solution;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] z_axis_low;
      logic signed [VALUE_W-1:0] z_axis_high;
      logic [COUNT_W-1:0]        level_count;
   } cfg_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] z_a;
      logic signed [VALUE_W-1:0] z_b;
      logic signed [VALUE_W-1:0] x_a;
      logic signed [VALUE_W-1:0] x_b;
      logic signed [VALUE_W-1:0] y_a;
      logic signed [VALUE_W-1:0] y_b;
   } endpoint_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]        level_index;
      logic signed [VALUE_W-1:0] level;
      logic                      no_solution;
      endpoint_type              start_pt;
      endpoint_type              end_pt;
      logic                      last;
   } job_type;

endpackage

// ===== hw/rtl/qcse_div.sv =====
// Restoring divider, one quotient bit per cycle, rounded to nearest with ties up.
module qcse_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W+1:0] rem_dbl;

   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_dbl = {rem_ff, 1'b0};
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            quot_in = {quot_ff[NUM_W-2:0], ge};
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
         end else begin
            if (rem_dbl >= {2'b00, den_ff}) begin
               quot_in = quot_ff + NUM_W'(1);
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hw/rtl/qcse_front.sv =====
// Front end: takes a cell, walks the contour levels and classifies each crossing.
module qcse_front #(
   parameter int MAX_LEVELS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  qcse_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  qcse_pkg::req_type req_data,
   output logic              job_valid,
   input  logic              job_ready,
   output qcse_pkg::job_type job
);

   localparam int V  = qcse_pkg::VALUE_W;
   localparam int KW = $clog2(MAX_LEVELS);
   localparam int NW = (KW + 1 > qcse_pkg::COUNT_W) ? KW + 1 : qcse_pkg::COUNT_W;
   localparam int PW = V + KW;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_DIV   = 5'b00100,
      S_CLASS = 5'b01000,
      S_FLUSH = 5'b10000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic signed [V-1:0] cx_ff [4];
   logic signed [V-1:0] cy_ff [4];
   logic signed [V-1:0] cz_ff [4];
   logic signed [V-1:0] rx [4];
   logic signed [V-1:0] ry [4];
   logic signed [V-1:0] rz [4];
   logic signed [V-1:0] zmin_ff, zmax_ff, zmin_in, zmax_in;
   logic signed [V-1:0] c_ff, c_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [PW-1:0]       prod_ff;
   logic                start_ff;
   qcse_pkg::job_type   pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;

   logic [NW-1:0]       count_ext, n_eff;
   logic [KW-1:0]       last_k;
   logic signed [V:0]   diff;
   logic [V-1:0]        magd;
   logic                div_done;
   logic [PW-1:0]       div_quot;
   logic [V-1:0]        q_v;
   logic                flat, in_range, advance;
   logic signed [1:0]   sg [4];
   logic signed [1:0]   a, b, cc, d;
   logic [1:0]          p0, p1, p2, p3;
   logic                found, s_edge, e_edge;
   logic [1:0]          s_idx, e_idx, s_nxt, e_nxt;
   qcse_pkg::job_type   new_job;

   always_comb begin
      rx[0] = req_data.corner0_x; ry[0] = req_data.corner0_y; rz[0] = req_data.corner0_z;
      rx[1] = req_data.corner1_x; ry[1] = req_data.corner1_y; rz[1] = req_data.corner1_z;
      rx[2] = req_data.corner2_x; ry[2] = req_data.corner2_y; rz[2] = req_data.corner2_z;
      rx[3] = req_data.corner3_x; ry[3] = req_data.corner3_y; rz[3] = req_data.corner3_z;
      flat = (rz[0] == rz[1]) && (rz[0] == rz[2]) && (rz[0] == rz[3]);
      zmin_in = rz[0];
      zmax_in = rz[0];
      for (int j = 1; j < 4; j++) begin
         if (rz[j] < zmin_in) zmin_in = rz[j];
         if (rz[j] > zmax_in) zmax_in = rz[j];
      end
   end

   always_comb begin
      count_ext = NW'(cfg.level_count);
      if (count_ext < NW'(2)) begin
         n_eff = NW'(2);
      end else if (count_ext > NW'(MAX_LEVELS)) begin
         n_eff = NW'(MAX_LEVELS);
      end else begin
         n_eff = count_ext;
      end
      last_k = KW'(n_eff - NW'(1));
      diff   = $signed({cfg.z_axis_high[V-1], cfg.z_axis_high})
             - $signed({cfg.z_axis_low[V-1], cfg.z_axis_low});
      magd   = diff[V] ? V'(-diff) : V'(diff);
      q_v    = div_quot[V-1:0];
      c_in   = diff[V] ? cfg.z_axis_low - $signed(q_v) : cfg.z_axis_low + $signed(q_v);
   end

   qcse_div #(
      .NUM_W(PW),
      .DEN_W(KW)
   ) u_level_div (
      .clock(clock),
      .reset(reset),
      .start(start_ff),
      .num  (prod_ff),
      .den  (last_k),
      .done (div_done),
      .quot (div_quot)
   );

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sg[j] = (cz_ff[j] < c_ff) ? -2'sd1 : ((cz_ff[j] > c_ff) ? 2'sd1 : 2'sd0);
      end
      in_range = (zmin_ff < c_ff) && (c_ff < zmax_ff);
      found  = 1'b0;
      s_edge = 1'b0;
      e_edge = 1'b0;
      s_idx  = 2'd0;
      e_idx  = 2'd0;
      for (int i = 0; i < 4; i++) begin
         p0 = 2'(i);
         p1 = 2'(i + 1);
         p2 = 2'(i + 2);
         p3 = 2'(i + 3);
         a  = sg[p0];
         b  = sg[p1];
         cc = sg[p2];
         d  = sg[p3];
         if (!found) begin
            if (a != 0 && b == -a && cc == a && d == a) begin
               found = 1'b1; s_edge = 1'b1; s_idx = p0; e_edge = 1'b1; e_idx = p1;
            end else if (a != 0 && b == -a && cc != 0 && d == -cc) begin
               found = 1'b1; s_edge = 1'b1; s_idx = p0; e_edge = 1'b1; e_idx = p2;
            end else if (a == 0 && b != 0 && cc == -b && d == cc) begin
               found = 1'b1; s_edge = 1'b0; s_idx = p0; e_edge = 1'b1; e_idx = p1;
            end else if (a == 0 && b != 0 && cc == b && d == -b) begin
               found = 1'b1; s_edge = 1'b0; s_idx = p0; e_edge = 1'b1; e_idx = p2;
            end else if (a == 0 && b == 0 && cc != 0 && d != 0) begin
               found = 1'b1; s_edge = 1'b0; s_idx = p0; e_edge = 1'b0; e_idx = p1;
            end else if (a == 0 && b != 0 && cc == 0 && d != 0) begin
               found = 1'b1; s_edge = 1'b0; s_idx = p0; e_edge = 1'b0; e_idx = p2;
            end else if (a == 0 && b == 0 && cc == 0 && d != 0) begin
               found = 1'b1; s_edge = 1'b0; s_idx = p0; e_edge = 1'b0; e_idx = p2;
            end
         end
      end
      s_nxt = s_edge ? s_idx + 2'd1 : s_idx;
      e_nxt = e_edge ? e_idx + 2'd1 : e_idx;
      new_job.level_index = qcse_pkg::LEVEL_W'(k_ff);
      new_job.level       = c_ff;
      new_job.no_solution = !found;
      new_job.last        = 1'b0;
      if (found) begin
         new_job.start_pt.z_a = cz_ff[s_idx];
         new_job.start_pt.z_b = cz_ff[s_nxt];
         new_job.start_pt.x_a = cx_ff[s_idx];
         new_job.start_pt.x_b = cx_ff[s_nxt];
         new_job.start_pt.y_a = cy_ff[s_idx];
         new_job.start_pt.y_b = cy_ff[s_nxt];
         new_job.end_pt.z_a   = cz_ff[e_idx];
         new_job.end_pt.z_b   = cz_ff[e_nxt];
         new_job.end_pt.x_a   = cx_ff[e_idx];
         new_job.end_pt.x_b   = cx_ff[e_nxt];
         new_job.end_pt.y_a   = cy_ff[e_idx];
         new_job.end_pt.y_b   = cy_ff[e_nxt];
      end else begin
         new_job.start_pt = '0;
         new_job.end_pt   = '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      job_valid     = 1'b0;
      job           = pend_ff;
      advance       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !flat) begin
               state_in = S_MUL;
               k_in     = '0;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (in_range) begin
               job_valid = pend_valid_ff;
               if (!pend_valid_ff || job_ready) begin
                  pend_in       = new_job;
                  pend_valid_in = 1'b1;
                  advance       = 1'b1;
               end
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               if (k_ff == last_k) begin
                  state_in = S_FLUSH;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = S_MUL;
               end
            end
         end
         S_FLUSH: begin
            job.last  = 1'b1;
            job_valid = pend_valid_ff;
            if (!pend_valid_ff || job_ready) begin
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         for (int j = 0; j < 4; j++) begin
            cx_ff[j] <= rx[j];
            cy_ff[j] <= ry[j];
            cz_ff[j] <= rz[j];
         end
         zmin_ff <= zmin_in;
         zmax_ff <= zmax_in;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= PW'(magd) * PW'(k_ff);
      end
      if (state_ff == S_DIV && div_done) begin
         c_ff <= c_in;
      end
      k_ff    <= k_in;
      pend_ff <= pend_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         start_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_ff      <= (state_ff == S_MUL);
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

// ===== hw/rtl/qcse_queue.sv =====
// Two-entry queue of classified segment jobs between front and back end.
module qcse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  qcse_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output qcse_pkg::job_type pop_data
);

   qcse_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

// ===== hw/rtl/qcse_back.sv =====
// Back end: interpolates the four segment coordinates of a job and holds the result.
module qcse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  qcse_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qcse_pkg::rsp_type rsp_data
);

   localparam int V  = qcse_pkg::VALUE_W;
   localparam int PW = 2 * V;

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_SETUP = 5'b00010,
      B_MUL   = 5'b00100,
      B_DIV   = 5'b01000,
      B_EMIT  = 5'b10000
   } back_state_type;

   back_state_type      state_ff, state_in;
   qcse_pkg::job_type   job_ff;
   logic [1:0]          op_ff, op_in;
   logic signed [V-1:0] res_ff [4];
   logic [V-1:0]        magdv_ff, magdc_ff, magdz_ff;
   logic signed [V-1:0] v1_ff;
   logic                neg_ff, trivial_ff, start_ff;
   logic [PW-1:0]       prod_ff;
   qcse_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;

   qcse_pkg::endpoint_type pt;
   logic signed [V-1:0] z1, z2, v1, v2;
   logic signed [V:0]   dv, dc, dz;
   logic                div_done;
   logic [PW-1:0]       div_quot;
   logic [V-1:0]        q_v;
   logic signed [V-1:0] interp_res;
   logic                out_free, write_res;

   always_comb begin
      pt = op_ff[1] ? job_ff.end_pt : job_ff.start_pt;
      z1 = pt.z_a;
      z2 = pt.z_b;
      v1 = op_ff[0] ? pt.y_a : pt.x_a;
      v2 = op_ff[0] ? pt.y_b : pt.x_b;
      dv = $signed({v2[V-1], v2}) - $signed({v1[V-1], v1});
      dc = $signed({job_ff.level[V-1], job_ff.level}) - $signed({z1[V-1], z1});
      dz = $signed({z2[V-1], z2}) - $signed({z1[V-1], z1});
      q_v = div_quot[V-1:0];
      interp_res = neg_ff ? v1_ff - $signed(q_v) : v1_ff + $signed(q_v);
   end

   qcse_div #(
      .NUM_W(PW),
      .DEN_W(V)
   ) u_interp_div (
      .clock(clock),
      .reset(reset),
      .start(start_ff),
      .num  (prod_ff),
      .den  (magdz_ff),
      .done (div_done),
      .quot (div_quot)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      job_ready = 1'b0;
      write_res = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               op_in    = 2'd0;
               state_in = B_SETUP;
            end
         end
         B_SETUP: begin
            state_in = B_MUL;
         end
         B_MUL: begin
            if (trivial_ff) begin
               write_res = 1'b1;
            end else begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            write_res = div_done;
         end
         B_EMIT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (write_res) begin
         if (op_ff == 2'd3) begin
            state_in = B_EMIT;
         end else begin
            op_in    = op_ff + 2'd1;
            state_in = B_SETUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && job_valid) begin
         job_ff <= job;
      end
      if (state_ff == B_SETUP) begin
         magdv_ff   <= dv[V] ? V'(-dv) : V'(dv);
         magdc_ff   <= dc[V] ? V'(-dc) : V'(dc);
         magdz_ff   <= dz[V] ? V'(-dz) : V'(dz);
         v1_ff      <= v1;
         neg_ff     <= dv[V] ^ dc[V] ^ dz[V];
         trivial_ff <= (dv == '0) || (dc == '0) || (dz == '0);
      end
      if (state_ff == B_MUL) begin
         prod_ff <= PW'(magdv_ff) * PW'(magdc_ff);
      end
      if (write_res) begin
         res_ff[op_ff] <= (state_ff == B_MUL) ? v1_ff : interp_res;
      end
      if (state_ff == B_EMIT && out_free) begin
         rsp_ff.level_index <= job_ff.level_index;
         rsp_ff.start_x     <= res_ff[0];
         rsp_ff.start_y     <= res_ff[1];
         rsp_ff.end_x       <= res_ff[2];
         rsp_ff.end_y       <= res_ff[3];
         rsp_ff.no_solution <= job_ff.no_solution;
         rsp_ff.last        <= job_ff.last;
      end
      op_ff <= op_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == B_MUL) && !trivial_ff;
         if (state_ff == B_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/quad_contour_segment_extractor_core.sv =====
// Top level of the quad contour segment extractor: configuration registers and the datapath.
// A cell is taken whenever the level walker is idle; a flat cell is dropped
// right away. The walker then takes the contour levels in turn, each through a multiply,
// its bit-serial level divider and classification. For each level that crosses the cell,
// the back end runs one 64-bit bit-serial interpolation division per output coordinate,
// fewer when a coordinate needs no division. A two-entry job queue lets the walker run
// ahead of the back end, and a result register lets the back end continue while a
// finished segment waits for transfer. Configuration writes are always accepted.
module quad_contour_segment_extractor_core #(
   parameter int MAX_LEVELS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  qcse_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output qcse_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [qcse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qcse_pkg::VALUE_W-1:0]         csr_wdata
);

   qcse_pkg::cfg_type cfg_ff;
   qcse_pkg::job_type push_job, pop_job;
   logic              push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.z_axis_low  <= qcse_pkg::Z_AXIS_LOW_RESET;
         cfg_ff.z_axis_high <= qcse_pkg::Z_AXIS_HIGH_RESET;
         cfg_ff.level_count <= qcse_pkg::LEVEL_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            qcse_pkg::CSR_Z_AXIS_LOW:  cfg_ff.z_axis_low  <= csr_wdata;
            qcse_pkg::CSR_Z_AXIS_HIGH: cfg_ff.z_axis_high <= csr_wdata;
            qcse_pkg::CSR_LEVEL_COUNT:
               cfg_ff.level_count <= csr_wdata[qcse_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   qcse_front #(
      .MAX_LEVELS(MAX_LEVELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .job_valid(push_valid),
      .job_ready(push_ready),
      .job      (push_job)
   );

   qcse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_job),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_job)
   );

   qcse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(pop_valid),
      .job_ready(pop_ready),
      .job      (pop_job),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
